FILE: hdl/sfd_pkg.sv
package sfd_pkg;

  // Default payload limit, frame overhead (start, hdr1, addr, cmd, length, checksum)
  localparam int MAX_PAYLOAD_DEF = 64;
  localparam int FRAME_OVH       = 6;
  localparam int RESULT_CAP      = 64;

  localparam logic [7:0] START_BYTE = 8'h5C;

  // Result kinds
  localparam logic KIND_NACK  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Per-frame summary kept between the scan and the emit pass
  typedef struct packed {
    logic [7:0] len;
    logic [7:0] nlen;
    logic [7:0] hdr1;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] chk;
  } frame_ent_t;

  // Hand-over from the scanner to the emitter
  typedef struct packed {
    logic       go;
    logic [6:0] nacks;
  } emit_req_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] nack_count;
    logic [7:0] frame_addr;
    logic [7:0] frame_hdr1;
    logic [7:0] frame_cmd;
    logic [6:0] payload_len;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [7:0] frame_checksum;
    logic       last;
  } result_t;

endpackage

FILE: hdl/sfd_win_ram.sv
module sfd_win_ram
  import sfd_pkg::*;
#(
  parameter int DEPTH = MAX_PAYLOAD_DEF + FRAME_OVH,
  parameter int AW    = $clog2(MAX_PAYLOAD_DEF + FRAME_OVH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re_a,
  input  logic [AW-1:0] raddr_a,
  output logic [7:0]    rdata_a,
  input  logic          re_b,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_b
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_a_r;
  logic [7:0] rd_b_r;

  // Read data holds until the port is read again
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_r <= mem[raddr_a];
    end
    if (re_b) begin
      rd_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

FILE: hdl/sfd_ftab_ram.sv
module sfd_ftab_ram
  import sfd_pkg::*;
#(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rdata = rd_r;

endmodule

FILE: hdl/sfd_scan.sv
module sfd_scan
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int DEPTH       = MAX_PAYLOAD_DEF + FRAME_OVH,
  parameter int AW          = 7,
  parameter int CW          = 7,
  parameter int FAW         = 4,
  parameter int FCW         = 4,
  parameter int TW          = 7 + $bits(frame_ent_t)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           byte_acc,
  input  logic [7:0]     byte_in,
  output logic           busy,
  output logic           win_we,
  output logic [AW-1:0]  win_waddr,
  output logic [7:0]     win_wdata,
  output logic           win_re_a,
  output logic [AW-1:0]  win_addr_a,
  output logic           win_re_b,
  output logic [AW-1:0]  win_addr_b,
  input  logic [7:0]     win_rd_a,
  input  logic [7:0]     win_rd_b,
  output logic           tab_we,
  output logic [FAW-1:0] tab_waddr,
  output logic [TW-1:0]  tab_wdata,
  output emit_req_t      req,
  output logic [FCW-1:0] nframes
);

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_FCHK, S_LEN, S_WALK, S_CHECK, S_HAND
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [7:0]     len_r, len_nxt;
  logic [7:0]     hdr1_r, hdr1_nxt;
  logic [7:0]     addr_r, addr_nxt;
  logic [7:0]     cmd_r, cmd_nxt;
  logic [7:0]     xor_r, xor_nxt;
  logic           pend_r, pend_nxt;
  logic [7:0]     npairs_r, npairs_nxt;
  logic [AW-1:0]  iss_k_r, iss_k_nxt;
  logic           dvld_r, dvld_nxt;
  logic [AW-1:0]  dk_r, dk_nxt;
  logic [6:0]     nacks_r, nacks_nxt;
  logic [FCW-1:0] nfr_r, nfr_nxt;

  logic [8:0]     last_k;
  logic [7:0]     nlen;
  logic [7:0]     new_chk;
  frame_ent_t     ent;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign last_k  = {1'b0, len_r} + 9'd4;
  assign nlen    = len_r - npairs_r;
  // Trailer matched, so recompute from it: collapsed pairs leave one start byte each
  assign new_chk = win_rd_b ^ len_r ^ nlen ^ (npairs_r[0] ? START_BYTE : 8'h00);

  always_comb begin
    ent      = '0;
    ent.len  = len_r;
    ent.nlen = nlen;
    ent.hdr1 = hdr1_r;
    ent.addr = addr_r;
    ent.cmd  = cmd_r;
    ent.chk  = new_chk;
  end

  assign tab_waddr = nfr_r[FAW-1:0];
  assign tab_wdata = {wrap_add(head_r, (AW+1)'(FRAME_OVH - 1)), ent};
  assign busy      = (state_r != S_IDLE);
  assign nframes   = nfr_r;
  assign req.go    = (state_r == S_HAND) && ((nfr_r != '0) || (nacks_r != '0));
  assign req.nacks = nacks_r;
  assign win_wdata = byte_in;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    hdr1_nxt   = hdr1_r;
    addr_nxt   = addr_r;
    cmd_nxt    = cmd_r;
    xor_nxt    = xor_r;
    pend_nxt   = pend_r;
    npairs_nxt = npairs_r;
    iss_k_nxt  = iss_k_r;
    dvld_nxt   = 1'b0;
    dk_nxt     = dk_r;
    nacks_nxt  = nacks_r;
    nfr_nxt    = nfr_r;
    win_we     = 1'b0;
    win_waddr  = wrap_add(head_r, (AW+1)'(cnt_r));
    win_re_a   = 1'b0;
    win_addr_a = head_r;
    win_re_b   = 1'b0;
    win_addr_b = wrap_add(head_r, (AW+1)'(1));
    tab_we     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (byte_acc) begin
          win_we    = 1'b1;
          nacks_nxt = '0;
          nfr_nxt   = '0;
          // Full window: overwrite and drop the oldest byte
          if (cnt_r == DEPTH_C) begin
            head_nxt = wrap_add(head_r, (AW+1)'(1));
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        if (cnt_r == '0) begin
          state_nxt = S_HAND;
        end else begin
          win_re_a  = 1'b1;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (win_rd_a != START_BYTE) begin
          head_nxt  = wrap_add(head_r, (AW+1)'(1));
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIND;
        end else if (cnt_r < CW'(5)) begin
          state_nxt = S_HAND;
        end else begin
          win_re_a   = 1'b1;
          win_addr_a = wrap_add(head_r, (AW+1)'(4));
          win_re_b   = 1'b1;
          state_nxt  = S_LEN;
        end
      end
      S_LEN: begin
        len_nxt  = win_rd_a;
        hdr1_nxt = win_rd_b;
        if (win_rd_a > MAX_LEN) begin
          head_nxt  = wrap_add(head_r, (AW+1)'(1));
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIND;
        end else if (10'(cnt_r) < (10'(win_rd_a) + 10'd6)) begin
          state_nxt = S_HAND;
        end else begin
          iss_k_nxt  = AW'(2);
          xor_nxt    = '0;
          pend_nxt   = 1'b0;
          npairs_nxt = '0;
          state_nxt  = S_WALK;
        end
      end
      S_WALK: begin
        // Issue one read a cycle over bytes 2..len+4, fetch the trailer once
        if (9'(iss_k_r) <= last_k) begin
          win_re_a   = 1'b1;
          win_addr_a = wrap_add(head_r, {1'b0, iss_k_r});
          dvld_nxt   = 1'b1;
          dk_nxt     = iss_k_r;
          iss_k_nxt  = iss_k_r + AW'(1);
        end
        if (iss_k_r == AW'(2)) begin
          win_re_b   = 1'b1;
          win_addr_b = wrap_add(head_r, (AW+1)'(9'(len_r) + 9'd5));
        end
        if (dvld_r) begin
          xor_nxt = xor_r ^ win_rd_a;
          if (dk_r == AW'(2)) begin
            addr_nxt = win_rd_a;
          end
          if (dk_r == AW'(3)) begin
            cmd_nxt = win_rd_a;
          end
          if (9'(dk_r) >= 9'd5) begin
            if (pend_r && (win_rd_a == START_BYTE)) begin
              npairs_nxt = npairs_r + 8'd1;
              pend_nxt   = 1'b0;
            end else begin
              pend_nxt = (win_rd_a == START_BYTE);
            end
          end
          if (9'(dk_r) == last_k) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (xor_r != win_rd_b) begin
          if (nacks_r != 7'h7F) begin
            nacks_nxt = nacks_r + 7'd1;
          end
          head_nxt = wrap_add(head_r, (AW+1)'(1));
          cnt_nxt  = cnt_r - CW'(1);
        end else begin
          tab_we   = 1'b1;
          nfr_nxt  = nfr_r + FCW'(1);
          head_nxt = wrap_add(head_r, (AW+1)'(9'(len_r) + 9'(FRAME_OVH)));
          cnt_nxt  = cnt_r - CW'(9'(len_r) + 9'(FRAME_OVH));
        end
        state_nxt = S_FIND;
      end
      S_HAND: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
      dvld_r  <= 1'b0;
      nacks_r <= '0;
      nfr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
      dvld_r  <= dvld_nxt;
      nacks_r <= nacks_nxt;
      nfr_r   <= nfr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    hdr1_r   <= hdr1_nxt;
    addr_r   <= addr_nxt;
    cmd_r    <= cmd_nxt;
    xor_r    <= xor_nxt;
    pend_r   <= pend_nxt;
    npairs_r <= npairs_nxt;
    iss_k_r  <= iss_k_nxt;
    dk_r     <= dk_nxt;
  end

endmodule

FILE: hdl/sfd_emit.sv
module sfd_emit
  import sfd_pkg::*;
#(
  parameter int DEPTH = MAX_PAYLOAD_DEF + FRAME_OVH,
  parameter int AW    = 7,
  parameter int FAW   = 4,
  parameter int FCW   = 4,
  parameter int TW    = 7 + $bits(frame_ent_t)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  emit_req_t      req,
  input  logic [FCW-1:0] nframes,
  output logic           busy,
  output logic           tab_re,
  output logic [FAW-1:0] tab_raddr,
  input  logic [TW-1:0]  tab_rdata,
  output logic           win_re,
  output logic [AW-1:0]  win_addr_a,
  output logic [AW-1:0]  win_addr_b,
  input  logic [7:0]     win_rd_a,
  input  logic [7:0]     win_rd_b,
  output logic           out_valid,
  input  logic           out_stall,
  output result_t        res_out
);

  localparam logic [AW:0] DEPTH_W = (AW+1)'(DEPTH);

  typedef enum logic [2:0] {E_IDLE, E_NACK, E_TAB, E_RD, E_USE} state_t;

  state_t         state_r, state_nxt;
  logic [6:0]     nacks_r, nacks_nxt;
  logic [FCW-1:0] nfr_r, nfr_nxt;
  logic [FCW-1:0] f_r, f_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [7:0]     j_r, j_nxt;
  logic [6:0]     res_r, res_nxt;
  logic           ov_r, ov_nxt;
  result_t        out_r, out_nxt;

  logic [AW-1:0]  ptr;
  frame_ent_t     ent;
  logic           slot_free;
  logic           pair;
  logic [8:0]     i_step;
  logic           fend;
  logic           lastf;
  logic           cap;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + off;
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign ptr       = tab_rdata[TW-1 -: AW];
  assign ent       = frame_ent_t'(tab_rdata[$bits(frame_ent_t)-1:0]);
  assign slot_free = !ov_r || !out_stall;
  assign pair      = (ent.len != 8'd0) && (win_rd_a == START_BYTE) &&
                     (win_rd_b == START_BYTE) && ((9'(i_r) + 9'd1) < 9'(ent.len));
  assign i_step    = 9'(i_r) + (pair ? 9'd2 : 9'd1);
  assign fend      = (ent.len == 8'd0) || (i_step >= 9'(ent.len));
  assign lastf     = ((f_r + FCW'(1)) == nfr_r);
  assign cap       = (res_r == 7'(RESULT_CAP - 1));

  assign busy       = (state_r != E_IDLE);
  assign tab_raddr  = f_r[FAW-1:0];
  assign win_addr_a = wrap_add(ptr, (AW+1)'(i_r));
  assign win_addr_b = wrap_add(ptr, (AW+1)'(9'(i_r) + 9'd1));
  assign out_valid  = ov_r;
  assign res_out    = out_r;

  always_comb begin
    state_nxt = state_r;
    nacks_nxt = nacks_r;
    nfr_nxt   = nfr_r;
    f_nxt     = f_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    res_nxt   = res_r;
    ov_nxt    = ov_r && out_stall;
    out_nxt   = out_r;
    tab_re    = 1'b0;
    win_re    = 1'b0;

    case (state_r)
      E_IDLE: begin
        if (req.go) begin
          nacks_nxt = req.nacks;
          nfr_nxt   = nframes;
          f_nxt     = '0;
          res_nxt   = '0;
          state_nxt = (nframes == '0) ? E_NACK : E_TAB;
        end
      end
      E_NACK: begin
        // Failures only: one report, fields other than the count and last held at zero
        if (slot_free) begin
          ov_nxt             = 1'b1;
          out_nxt            = '0;
          out_nxt.kind       = KIND_NACK;
          out_nxt.nack_count = nacks_r;
          out_nxt.last       = 1'b1;
          state_nxt          = E_IDLE;
        end
      end
      E_TAB: begin
        tab_re    = 1'b1;
        i_nxt     = '0;
        j_nxt     = '0;
        state_nxt = E_RD;
      end
      E_RD: begin
        win_re    = 1'b1;
        state_nxt = E_USE;
      end
      E_USE: begin
        if (slot_free) begin
          ov_nxt                 = 1'b1;
          out_nxt.kind           = KIND_FRAME;
          out_nxt.nack_count     = (res_r == 7'd0) ? nacks_r : 7'd0;
          out_nxt.frame_addr     = ent.addr;
          out_nxt.frame_hdr1     = ent.hdr1;
          out_nxt.frame_cmd      = ent.cmd;
          out_nxt.payload_len    = ent.nlen[6:0];
          out_nxt.payload_byte   = (ent.len == 8'd0) ? 8'd0 : win_rd_a;
          out_nxt.byte_index     = j_r[5:0];
          out_nxt.frame_checksum = ent.chk;
          out_nxt.last           = (fend && lastf) || cap;
          res_nxt                = res_r + 7'd1;
          i_nxt                  = i_step[7:0];
          j_nxt                  = j_r + 8'd1;
          if ((fend && lastf) || cap) begin
            state_nxt = E_IDLE;
          end else if (fend) begin
            f_nxt     = f_r + FCW'(1);
            state_nxt = E_TAB;
          end else begin
            state_nxt = E_RD;
          end
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nacks_r <= nacks_nxt;
    nfr_r   <= nfr_nxt;
    f_r     <= f_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule

FILE: hdl/serial_frame_deframer.sv
// Each byte holds the input while the scan runs; each dropped byte, each overlong length and
// each checksum walk lengthens the scan. Results: the first follows the scan's end through a
// table read, a window read and the output register (a failure-only report through the output
// register alone); each further byte adds a window read, each further frame a table read, and
// out_stall holds any result; both passes use the window reads, and the next byte waits for both.
// Reset: control state, window fill and out_valid clear synchronously; window memory is left as it is.
module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [6:0] out_nack_count,
  output logic [7:0] out_frame_addr,
  output logic [7:0] out_frame_hdr1,
  output logic [7:0] out_frame_cmd,
  output logic [6:0] out_payload_len,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic [7:0] out_frame_checksum,
  output logic       out_last
);

  // Window: circular buffer of unconsumed bytes, one full frame deep
  localparam int DEPTH = MAX_PAYLOAD + FRAME_OVH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  // Frame table: every frame that fits in one window
  localparam int FD    = DEPTH / FRAME_OVH + 1;
  localparam int FAW   = $clog2(FD);
  localparam int FCW   = $clog2(FD + 1);
  localparam int TW    = AW + $bits(frame_ent_t);

  logic           byte_acc;
  logic           scan_busy;
  logic           emit_busy;

  logic           sc_we;
  logic [AW-1:0]  sc_waddr;
  logic [7:0]     sc_wdata;
  logic           sc_re_a;
  logic [AW-1:0]  sc_addr_a;
  logic           sc_re_b;
  logic [AW-1:0]  sc_addr_b;
  logic           em_re;
  logic [AW-1:0]  em_addr_a;
  logic [AW-1:0]  em_addr_b;
  logic [7:0]     win_rd_a;
  logic [7:0]     win_rd_b;

  logic           tab_we;
  logic [FAW-1:0] tab_waddr;
  logic [TW-1:0]  tab_wdata;
  logic           tab_re;
  logic [FAW-1:0] tab_raddr;
  logic [TW-1:0]  tab_rdata;

  emit_req_t      req;
  logic [FCW-1:0] nframes;
  result_t        res;

  // Take a new byte only once the scan and emit passes of the last one are over;
  // the output register lets a finished result wait while the next byte comes in.
  assign in_stall = scan_busy || emit_busy;
  assign byte_acc = in_valid && !in_stall;

  // Pass one: append the byte, scan, count failures and log good frames
  sfd_scan #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .DEPTH       (DEPTH),
    .AW          (AW),
    .CW          (CW),
    .FAW         (FAW),
    .FCW         (FCW),
    .TW          (TW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_acc   (byte_acc),
    .byte_in    (in_rx_byte),
    .busy       (scan_busy),
    .win_we     (sc_we),
    .win_waddr  (sc_waddr),
    .win_wdata  (sc_wdata),
    .win_re_a   (sc_re_a),
    .win_addr_a (sc_addr_a),
    .win_re_b   (sc_re_b),
    .win_addr_b (sc_addr_b),
    .win_rd_a   (win_rd_a),
    .win_rd_b   (win_rd_b),
    .tab_we     (tab_we),
    .tab_waddr  (tab_waddr),
    .tab_wdata  (tab_wdata),
    .req        (req),
    .nframes    (nframes)
  );

  // Consumed frame bytes stay in the window memory until the next byte is
  // written, so pass two re-reads payloads from there. The passes never
  // overlap, so the read ports simply follow whichever is active.
  sfd_win_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_win (
    .clk     (clk),
    .we      (sc_we),
    .waddr   (sc_waddr),
    .wdata   (sc_wdata),
    .re_a    (emit_busy ? em_re : sc_re_a),
    .raddr_a (emit_busy ? em_addr_a : sc_addr_a),
    .rdata_a (win_rd_a),
    .re_b    (emit_busy ? em_re : sc_re_b),
    .raddr_b (emit_busy ? em_addr_b : sc_addr_b),
    .rdata_b (win_rd_b)
  );

  sfd_ftab_ram #(
    .DEPTH (FD),
    .AW    (FAW),
    .DW    (TW)
  ) u_ftab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .re    (tab_re),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  // Pass two: with the failure total known, unescape and deliver each frame
  sfd_emit #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .FAW   (FAW),
    .FCW   (FCW),
    .TW    (TW)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .nframes    (nframes),
    .busy       (emit_busy),
    .tab_re     (tab_re),
    .tab_raddr  (tab_raddr),
    .tab_rdata  (tab_rdata),
    .win_re     (em_re),
    .win_addr_a (em_addr_a),
    .win_addr_b (em_addr_b),
    .win_rd_a   (win_rd_a),
    .win_rd_b   (win_rd_b),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_out    (res)
  );

  assign out_kind           = res.kind;
  assign out_nack_count     = res.nack_count;
  assign out_frame_addr     = res.frame_addr;
  assign out_frame_hdr1     = res.frame_hdr1;
  assign out_frame_cmd      = res.frame_cmd;
  assign out_payload_len    = res.payload_len;
  assign out_payload_byte   = res.payload_byte;
  assign out_byte_index     = res.byte_index;
  assign out_frame_checksum = res.frame_checksum;
  assign out_last           = res.last;

endmodule
